// ===== rtl/core/ptf_pkg.sv =====
`timescale 1ns / 1ps
package ptf_pkg;

  localparam int POS_FRAC_BITS = 14;
  localparam int POS_W         = 16;

  localparam longint ONE_Q_L     = longint'(1) << POS_FRAC_BITS;
  localparam longint YAW_LIM_L   = (55 * ONE_Q_L + 50) / 100;
  localparam longint MIN_APPLY_L = (15 * ONE_Q_L + 500) / 1000;
  localparam longint SPD_FAR_L   = (35 * ONE_Q_L + 50) / 100;
  localparam longint SPD_MID_L   = (18 * ONE_Q_L + 50) / 100;

  localparam logic signed [POS_W-1:0] ONE_Q   = POS_W'(ONE_Q_L);
  localparam logic signed [POS_W-1:0] YAW_LIM = POS_W'(YAW_LIM_L);
  localparam logic [35:0] MIN_SQ     = 36'(MIN_APPLY_L * MIN_APPLY_L);
  localparam logic [35:0] SPD_FAR_SQ = 36'(SPD_FAR_L * SPD_FAR_L);
  localparam logic [35:0] SPD_MID_SQ = 36'(SPD_MID_L * SPD_MID_L);

  localparam logic signed [15:0] ALPHA_Q16 = 16'sd11796;

  localparam logic [6:0] SCAN_SPEED    = 7'd85;
  localparam logic [6:0] TRACK_SPEED   = 7'd110;
  localparam logic [6:0] SPEED_CAP_MID = 7'd105;
  localparam logic [6:0] SPEED_CAP_FAR = 7'd90;

  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_NET = 2'd1;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_IV   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DETECT_IV   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_TO     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_PITCH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_STEP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUTLIER_LIM = 3'd7;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_GATE, OP_SWEEP, OP_SMOOTH, OP_DIST, OP_SSQ,
    OP_APPLY, OP_DET_SCAN, OP_FDIST, OP_DET_TRK, OP_LOST
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_GATE, ST_SWEEP, ST_SMOOTH, ST_DIST, ST_SSQ, ST_APPLY,
    ST_DET_SCAN, ST_FDIST, ST_DET_TRK, ST_LOST, ST_OUT
  } state_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic tick_go;
    logic trk;
    logic lost;
  } status_t;

  function automatic logic [35:0] sq_sum(logic signed [16:0] a, logic signed [16:0] b);
    logic signed [33:0] pa;
    logic signed [33:0] pb;
    pa = a * a;
    pb = b * b;
    return 36'(unsigned'(pa)) + 36'(unsigned'(pb));
  endfunction

  // Exponential smoothing step, rounded half up.
  function automatic logic signed [15:0] smooth_axis(logic signed [15:0] cur,
                                                     logic signed [15:0] tgt);
    logic signed [16:0] d;
    logic signed [32:0] p;
    logic signed [32:0] q;
    d = {tgt[15], tgt} - {cur[15], cur};
    p = d * ALPHA_Q16;
    q = (p + 33'sd32768) >>> 16;
    return cur + q[15:0];
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [16:0] v);
    if (v[16] != v[15]) begin
      return v[16] ? 16'sh8000 : 16'sh7FFF;
    end
    return v[15:0];
  endfunction

endpackage

// ===== rtl/core/pan_tilt_face_follow_controller.sv =====
`timescale 1ns / 1ps
// Pan/tilt face-follow controller.
// Input channel (in_valid_i / in_stall_o): one tick item per transfer, with
// time, gating flags, detection result and the head position.
// Output channel (out_valid_o / out_stall_i): exactly one result per input
// item: move command (move_valid_o, position, speed) and the phase after
// the tick. Fields of a result without a move read as zero.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i;
// write only while no item is in flight.
// A skipped tick goes from the gate step straight to the result; a scanning
// tick sweeps, smooths, measures and applies the step, then runs detection;
// a tracking tick runs detection and the lost check, then smooths (not when
// lost), measures and applies the step. One item is worked on at a time;
// the sequencer walks the shared datapath one step a cycle.
// in_stall_o stays high from the transfer until the result has been taken.
// While the receiver stalls, the result holds and no new item is taken.
// Reset clears the phase to scanning, puts the sweep at its lower yaw limit
// and loads the configuration defaults; the block is ready the cycle after
// reset is released.
module pan_tilt_face_follow_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [31:0]                   now_ms_i,
  input  logic                          conversation_active_i,
  input  logic                          avatar_present_i,
  input  logic                          motion_held_i,
  input  logic                          face_found_i,
  input  logic signed [15:0]            face_x_i,
  input  logic signed [15:0]            face_y_i,
  input  logic signed [15:0]            head_x_i,
  input  logic signed [15:0]            head_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          move_valid_o,
  output logic signed [15:0]            move_x_o,
  output logic signed [15:0]            move_y_o,
  output logic [6:0]                    servo_speed_o,
  output logic                          phase_o,
  input  logic                          cfg_we_i,
  input  logic [ptf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ptf_pkg::CFG_W-1:0]     cfg_wdata_i
);

  ptf_pkg::cmd_t    cmd;
  ptf_pkg::status_t status;

  // sequencer: one datapath step per cycle
  ptf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  // state, config, smoothing, distance and step arithmetic
  ptf_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .status_o              (status),
    .cfg_we_i              (cfg_we_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .now_ms_i              (now_ms_i),
    .conversation_active_i (conversation_active_i),
    .avatar_present_i      (avatar_present_i),
    .motion_held_i         (motion_held_i),
    .face_found_i          (face_found_i),
    .face_x_i              (face_x_i),
    .face_y_i              (face_y_i),
    .head_x_i              (head_x_i),
    .head_y_i              (head_y_i),
    .move_valid_o          (move_valid_o),
    .move_x_o              (move_x_o),
    .move_y_o              (move_y_o),
    .servo_speed_o         (servo_speed_o),
    .phase_o               (phase_o)
  );

endmodule

// ===== rtl/core/ptf_ctrl.sv =====
`timescale 1ns / 1ps
module ptf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             out_stall_i,
  input  ptf_pkg::status_t status_i,
  output ptf_pkg::cmd_t    cmd_o,
  output logic             in_stall_o,
  output logic             out_valid_o
);

  ptf_pkg::state_e state_q, state_d;
  logic            scan_q, scan_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptf_pkg::ST_IDLE;
      scan_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    cmd_o.op   = ptf_pkg::OP_NONE;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ptf_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = ptf_pkg::OP_LOAD;
          state_d  = ptf_pkg::ST_GATE;
        end
      end
      ptf_pkg::ST_GATE: begin
        cmd_o.op = ptf_pkg::OP_GATE;
        scan_d   = !status_i.trk;
        if (!status_i.tick_go) begin
          state_d = ptf_pkg::ST_OUT;
        end else if (status_i.trk) begin
          state_d = ptf_pkg::ST_FDIST;
        end else begin
          state_d = ptf_pkg::ST_SWEEP;
        end
      end
      ptf_pkg::ST_SWEEP: begin
        cmd_o.op = ptf_pkg::OP_SWEEP;
        state_d  = ptf_pkg::ST_SMOOTH;
      end
      ptf_pkg::ST_SMOOTH: begin
        cmd_o.op = ptf_pkg::OP_SMOOTH;
        state_d  = ptf_pkg::ST_DIST;
      end
      ptf_pkg::ST_DIST: begin
        cmd_o.op = ptf_pkg::OP_DIST;
        state_d  = ptf_pkg::ST_SSQ;
      end
      ptf_pkg::ST_SSQ: begin
        cmd_o.op = ptf_pkg::OP_SSQ;
        state_d  = ptf_pkg::ST_APPLY;
      end
      ptf_pkg::ST_APPLY: begin
        cmd_o.op = ptf_pkg::OP_APPLY;
        state_d  = scan_q ? ptf_pkg::ST_DET_SCAN : ptf_pkg::ST_OUT;
      end
      ptf_pkg::ST_DET_SCAN: begin
        cmd_o.op = ptf_pkg::OP_DET_SCAN;
        state_d  = ptf_pkg::ST_OUT;
      end
      ptf_pkg::ST_FDIST: begin
        cmd_o.op = ptf_pkg::OP_FDIST;
        state_d  = ptf_pkg::ST_DET_TRK;
      end
      ptf_pkg::ST_DET_TRK: begin
        cmd_o.op = ptf_pkg::OP_DET_TRK;
        state_d  = ptf_pkg::ST_LOST;
      end
      ptf_pkg::ST_LOST: begin
        cmd_o.op = ptf_pkg::OP_LOST;
        state_d  = status_i.lost ? ptf_pkg::ST_DIST : ptf_pkg::ST_SMOOTH;
      end
      ptf_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = ptf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ptf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/ptf_dp.sv =====
`timescale 1ns / 1ps
module ptf_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ptf_pkg::cmd_t                        cmd_i,
  output ptf_pkg::status_t                     status_o,
  input  logic                                 cfg_we_i,
  input  logic [ptf_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [ptf_pkg::CFG_W-1:0]            cfg_wdata_i,
  input  logic [31:0]                          now_ms_i,
  input  logic                                 conversation_active_i,
  input  logic                                 avatar_present_i,
  input  logic                                 motion_held_i,
  input  logic                                 face_found_i,
  input  logic signed [15:0]                   face_x_i,
  input  logic signed [15:0]                   face_y_i,
  input  logic signed [15:0]                   head_x_i,
  input  logic signed [15:0]                   head_y_i,
  output logic                                 move_valid_o,
  output logic signed [15:0]                   move_x_o,
  output logic signed [15:0]                   move_y_o,
  output logic [6:0]                           servo_speed_o,
  output logic                                 phase_o
);

  // configuration
  logic [1:0]         run_mode_q;
  logic [15:0]        upd_iv_q, det_iv_q, lost_to_q;
  logic signed [15:0] pitch_q;
  logic [14:0]        ystep_q, max_step_q;
  logic [29:0]        ol_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_mode_q <= ptf_pkg::MODE_OFF;
      upd_iv_q   <= 16'd120;
      det_iv_q   <= 16'd380;
      lost_to_q  <= 16'd1600;
      pitch_q    <= 16'sd6226;
      ystep_q    <= 15'd573;
      max_step_q <= 15'd1966;
      ol_sq_q    <= 30'(32'd8192 * 32'd8192);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ptf_pkg::REG_RUN_MODE:    run_mode_q <= cfg_wdata_i[1:0];
        ptf_pkg::REG_UPDATE_IV:   upd_iv_q   <= cfg_wdata_i;
        ptf_pkg::REG_DETECT_IV:   det_iv_q   <= cfg_wdata_i;
        ptf_pkg::REG_LOST_TO:     lost_to_q  <= cfg_wdata_i;
        ptf_pkg::REG_SCAN_PITCH:  pitch_q    <= signed'(cfg_wdata_i);
        ptf_pkg::REG_SCAN_STEP:   ystep_q    <= cfg_wdata_i[14:0];
        ptf_pkg::REG_MAX_STEP:    max_step_q <= cfg_wdata_i[14:0];
        ptf_pkg::REG_OUTLIER_LIM: ol_sq_q    <= cfg_wdata_i[14:0] * cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  // controller state
  logic               trk_q, trk_d, down_q, down_d, primed_q, primed_d;
  logic signed [15:0] goal_x_q, goal_x_d, goal_y_q, goal_y_d;
  logic signed [15:0] sm_x_q, sm_x_d, sm_y_q, sm_y_d, sweep_q, sweep_d;
  logic [31:0]        last_tick_q, last_tick_d, last_det_q, last_det_d;
  logic [31:0]        last_seen_q, last_seen_d;

  // latched item and scratch
  logic [31:0]        now_q, now_d;
  logic               conv_q, conv_d, avatar_q, avatar_d, held_q, held_d;
  logic               found_q, found_d;
  logic signed [15:0] fx_q, fx_d, fy_q, fy_d, hx_q, hx_d, hy_q, hy_d;
  logic [35:0]        dsq_q, dsq_d, ssq_q, ssq_d, fd2_q, fd2_d;
  logic signed [16:0] stx_q, stx_d, sty_q, sty_d;

  // result
  logic               mv_q, mv_d;
  logic signed [15:0] mx_q, mx_d, my_q, my_d;
  logic [6:0]         spd_q, spd_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_q       <= 1'b0;
      down_q      <= 1'b0;
      primed_q    <= 1'b0;
      goal_x_q    <= -ptf_pkg::YAW_LIM;
      goal_y_q    <= 16'sd6226;
      sm_x_q      <= -ptf_pkg::YAW_LIM;
      sm_y_q      <= 16'sd6226;
      sweep_q     <= -ptf_pkg::YAW_LIM;
      last_tick_q <= '0;
      last_det_q  <= '0;
      last_seen_q <= '0;
      mv_q        <= 1'b0;
      mx_q        <= '0;
      my_q        <= '0;
      spd_q       <= '0;
    end else begin
      trk_q       <= trk_d;
      down_q      <= down_d;
      primed_q    <= primed_d;
      goal_x_q    <= goal_x_d;
      goal_y_q    <= goal_y_d;
      sm_x_q      <= sm_x_d;
      sm_y_q      <= sm_y_d;
      sweep_q     <= sweep_d;
      last_tick_q <= last_tick_d;
      last_det_q  <= last_det_d;
      last_seen_q <= last_seen_d;
      mv_q        <= mv_d;
      mx_q        <= mx_d;
      my_q        <= my_d;
      spd_q       <= spd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q    <= now_d;
    conv_q   <= conv_d;
    avatar_q <= avatar_d;
    held_q   <= held_d;
    found_q  <= found_d;
    fx_q     <= fx_d;
    fy_q     <= fy_d;
    hx_q     <= hx_d;
    hy_q     <= hy_d;
    dsq_q    <= dsq_d;
    ssq_q    <= ssq_d;
    fd2_q    <= fd2_d;
    stx_q    <= stx_d;
    sty_q    <= sty_d;
  end

  logic [31:0]        el_tick, el_det, el_seen;
  logic               det_due, detect_ok, tick_go;
  logic signed [17:0] sweep_sum;
  logic signed [16:0] dx, dy, ms;
  logic [6:0]         base_spd;

  assign el_tick   = now_q - last_tick_q;
  assign el_det    = now_q - last_det_q;
  assign el_seen   = now_q - last_seen_q;
  assign det_due   = el_det >= {16'd0, det_iv_q};
  assign detect_ok = (run_mode_q == ptf_pkg::MODE_NET) && found_q;
  assign tick_go   = (run_mode_q != ptf_pkg::MODE_OFF) && conv_q && avatar_q
                     && (el_tick >= {16'd0, upd_iv_q});

  assign status_o.tick_go = tick_go;
  assign status_o.trk     = trk_q;
  assign status_o.lost    = el_seen > {16'd0, lost_to_q};

  assign sweep_sum = {{2{sweep_q[15]}}, sweep_q}
                   + (down_q ? -$signed({3'b0, ystep_q}) : $signed({3'b0, ystep_q}));
  assign dx        = {sm_x_q[15], sm_x_q} - {hx_q[15], hx_q};
  assign dy        = {sm_y_q[15], sm_y_q} - {hy_q[15], hy_q};
  assign ms        = $signed({2'b0, max_step_q});
  assign base_spd  = trk_q ? ptf_pkg::TRACK_SPEED : ptf_pkg::SCAN_SPEED;

  function automatic logic signed [16:0] limit(logic signed [16:0] d,
                                               logic signed [16:0] m);
    if (d > m) return m;
    if (d < -m) return -m;
    return d;
  endfunction

  function automatic logic signed [15:0] clamp_one(logic signed [15:0] v);
    if (v > ptf_pkg::ONE_Q) return ptf_pkg::ONE_Q;
    if (v < -ptf_pkg::ONE_Q) return -ptf_pkg::ONE_Q;
    return v;
  endfunction

  always_comb begin
    trk_d       = trk_q;
    down_d      = down_q;
    primed_d    = primed_q;
    goal_x_d    = goal_x_q;
    goal_y_d    = goal_y_q;
    sm_x_d      = sm_x_q;
    sm_y_d      = sm_y_q;
    sweep_d     = sweep_q;
    last_tick_d = last_tick_q;
    last_det_d  = last_det_q;
    last_seen_d = last_seen_q;
    now_d       = now_q;
    conv_d      = conv_q;
    avatar_d    = avatar_q;
    held_d      = held_q;
    found_d     = found_q;
    fx_d        = fx_q;
    fy_d        = fy_q;
    hx_d        = hx_q;
    hy_d        = hy_q;
    dsq_d       = dsq_q;
    ssq_d       = ssq_q;
    fd2_d       = fd2_q;
    stx_d       = stx_q;
    sty_d       = sty_q;
    mv_d        = mv_q;
    mx_d        = mx_q;
    my_d        = my_q;
    spd_d       = spd_q;
    case (cmd_i.op)
      ptf_pkg::OP_LOAD: begin
        now_d    = now_ms_i;
        conv_d   = conversation_active_i;
        avatar_d = avatar_present_i;
        held_d   = motion_held_i;
        found_d  = face_found_i;
        fx_d     = clamp_one(face_x_i);
        fy_d     = clamp_one(face_y_i);
        hx_d     = head_x_i;
        hy_d     = head_y_i;
        mv_d     = 1'b0;
        mx_d     = '0;
        my_d     = '0;
        spd_d    = '0;
      end
      ptf_pkg::OP_GATE: begin
        if ((run_mode_q != ptf_pkg::MODE_OFF) && !conv_q && (trk_q || primed_q)) begin
          trk_d       = 1'b0;
          sweep_d     = -ptf_pkg::YAW_LIM;
          down_d      = 1'b0;
          goal_x_d    = -ptf_pkg::YAW_LIM;
          goal_y_d    = pitch_q;
          sm_x_d      = -ptf_pkg::YAW_LIM;
          sm_y_d      = pitch_q;
          primed_d    = 1'b0;
          last_det_d  = '0;
          last_seen_d = '0;
        end
        if (tick_go) begin
          last_tick_d = now_q;
        end
      end
      ptf_pkg::OP_SWEEP: begin
        // bounce between the yaw limits
        if (sweep_sum >= 18'(ptf_pkg::YAW_LIM)) begin
          sweep_d = ptf_pkg::YAW_LIM;
          down_d  = 1'b1;
        end else if (sweep_sum <= -18'(ptf_pkg::YAW_LIM)) begin
          sweep_d = -ptf_pkg::YAW_LIM;
          down_d  = 1'b0;
        end else begin
          sweep_d = sweep_sum[15:0];
        end
        goal_x_d = sweep_d;
        goal_y_d = pitch_q;
      end
      ptf_pkg::OP_SMOOTH: begin
        if (!primed_q) begin
          sm_x_d   = goal_x_q;
          sm_y_d   = goal_y_q;
          primed_d = 1'b1;
        end else begin
          sm_x_d = ptf_pkg::smooth_axis(sm_x_q, goal_x_q);
          sm_y_d = ptf_pkg::smooth_axis(sm_y_q, goal_y_q);
        end
      end
      ptf_pkg::OP_DIST: begin
        dsq_d = ptf_pkg::sq_sum(dx, dy);
        stx_d = limit(dx, ms);
        sty_d = limit(dy, ms);
      end
      ptf_pkg::OP_SSQ: begin
        ssq_d = ptf_pkg::sq_sum(stx_q, sty_q);
      end
      ptf_pkg::OP_APPLY: begin
        if (!held_q && (dsq_q >= ptf_pkg::MIN_SQ)) begin
          if (trk_q && (dsq_q > {6'd0, ol_sq_q})) begin
            // outlier: drop the move and rescan
            trk_d       = 1'b0;
            sweep_d     = -ptf_pkg::YAW_LIM;
            down_d      = 1'b0;
            goal_x_d    = -ptf_pkg::YAW_LIM;
            goal_y_d    = pitch_q;
            sm_x_d      = -ptf_pkg::YAW_LIM;
            sm_y_d      = pitch_q;
            primed_d    = 1'b0;
            last_det_d  = '0;
            last_seen_d = '0;
          end else begin
            mv_d = 1'b1;
            mx_d = ptf_pkg::sat16({hx_q[15], hx_q} + stx_q);
            my_d = ptf_pkg::sat16({hy_q[15], hy_q} + sty_q);
            if ((ssq_q > ptf_pkg::SPD_FAR_SQ) && (base_spd > ptf_pkg::SPEED_CAP_FAR)) begin
              spd_d = ptf_pkg::SPEED_CAP_FAR;
            end else if ((ssq_q <= ptf_pkg::SPD_FAR_SQ) && (ssq_q > ptf_pkg::SPD_MID_SQ)
                         && (base_spd > ptf_pkg::SPEED_CAP_MID)) begin
              spd_d = ptf_pkg::SPEED_CAP_MID;
            end else begin
              spd_d = base_spd;
            end
          end
        end
      end
      ptf_pkg::OP_DET_SCAN: begin
        if (det_due) begin
          last_det_d = now_q;
          if (detect_ok) begin
            trk_d       = 1'b1;
            goal_x_d    = fx_q;
            goal_y_d    = fy_q;
            last_seen_d = now_q;
            sm_x_d      = fx_q;
            sm_y_d      = fy_q;
            primed_d    = 1'b1;
          end
        end
      end
      ptf_pkg::OP_FDIST: begin
        fd2_d = ptf_pkg::sq_sum({fx_q[15], fx_q} - {goal_x_q[15], goal_x_q},
                                {fy_q[15], fy_q} - {goal_y_q[15], goal_y_q});
      end
      ptf_pkg::OP_DET_TRK: begin
        if (det_due) begin
          last_det_d = now_q;
          if (detect_ok && (fd2_q <= {6'd0, ol_sq_q})) begin
            goal_x_d    = fx_q;
            goal_y_d    = fy_q;
            last_seen_d = now_q;
          end
        end
      end
      ptf_pkg::OP_LOST: begin
        if (status_o.lost) begin
          trk_d       = 1'b0;
          sweep_d     = -ptf_pkg::YAW_LIM;
          down_d      = 1'b0;
          goal_x_d    = -ptf_pkg::YAW_LIM;
          goal_y_d    = pitch_q;
          sm_x_d      = -ptf_pkg::YAW_LIM;
          sm_y_d      = pitch_q;
          primed_d    = 1'b1;
          last_det_d  = '0;
          last_seen_d = '0;
        end
      end
      default: ;
    endcase
  end

  assign move_valid_o  = mv_q;
  assign move_x_o      = mx_q;
  assign move_y_o      = my_q;
  assign servo_speed_o = spd_q;
  assign phase_o       = trk_q;

endmodule

// ===== rtl/core/ptf_checker.sv =====
`timescale 1ns / 1ps
module ptf_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              move_valid_o,
  input logic signed [15:0] move_x_o,
  input logic signed [15:0] move_y_o,
  input logic [6:0]        servo_speed_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o)
    else $error("result shown in the cycle after input transfer");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result waits");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !move_valid_o |-> move_x_o == 16'sd0 && move_y_o == 16'sd0
                                     && servo_speed_o == 7'd0)
    else $error("fields of an empty move not zero");

  a_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && move_valid_o |-> servo_speed_o == ptf_pkg::SCAN_SPEED
                                    || servo_speed_o == ptf_pkg::SPEED_CAP_FAR
                                    || servo_speed_o == ptf_pkg::SPEED_CAP_MID
                                    || servo_speed_o == ptf_pkg::TRACK_SPEED)
    else $error("illegal move speed");

endmodule

bind pan_tilt_face_follow_controller ptf_checker u_ptf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .move_valid_o  (move_valid_o),
  .move_x_o      (move_x_o),
  .move_y_o      (move_y_o),
  .servo_speed_o (servo_speed_o)
);
